### rtl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies; every other file in rtl/ imports this package.
package qrs_pkg;

	localparam int COEF_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int STATUS_BITS = 2;
	localparam int DISC_BITS   = 34;
	localparam int ROOT_BITS   = 34;
	localparam int OUT_BITS    = STATUS_BITS + DISC_BITS + 2 * ROOT_BITS;
	localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_A_ZERO  = 2'd0,
		ST_NO_REAL = 2'd1,
		ST_DOUBLE  = 2'd2,
		ST_TWO     = 2'd3
	} status_t;

endpackage

### rtl/qrs_sqrt_cell.sv
// One cell of the square-root chain: resolves one root bit per cycle while en is high.
// Depends on qrs_pkg (imported for house consistency).
module qrs_sqrt_cell #(
	parameter int P  = 33,
	parameter int SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*P-1:0]  in_rad,
	input  logic [P-1:0]    in_root,
	input  logic [P+2:0]    in_rem,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [2*P-1:0]  out_rad,
	output logic [P-1:0]    out_root,
	output logic [P+2:0]    out_rem,
	output logic [SW-1:0]   out_side
);
	import qrs_pkg::*;

	logic [P+2:0] remx;
	logic [P+2:0] trial;
	logic         ge;

	// bring down the next radicand pair and try root*4+1
	assign remx  = {in_rem[P:0], in_rad[2*P-1:2*P-2]};
	assign trial = {1'b0, in_root, 2'b01};
	assign ge    = (remx >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rad  <= {in_rad[2*P-3:0], 2'b00};
			out_root <= {in_root[P-2:0], ge};
			out_rem  <= ge ? (remx - trial) : remx;
			out_side <= in_side;
		end
	end

endmodule

### rtl/qrs_div_cell.sv
// One cell of the divider chain: one quotient bit per cycle for both roots while en is high.
// Depends on qrs_pkg (imported for house consistency).
module qrs_div_cell #(
	parameter int QW = 34,
	parameter int DW = 17,
	parameter int SW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [QW-1:0]  in_num [2],
	input  logic [DW-1:0]  in_rem [2],
	input  logic [DW-1:0]  in_den,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [QW-1:0]  out_num [2],
	output logic [DW-1:0]  out_rem [2],
	output logic [DW-1:0]  out_den,
	output logic [SW-1:0]  out_side
);
	import qrs_pkg::*;

	logic [DW:0] remx [2];
	logic [DW:0] dx;
	logic        ge   [2];

	assign dx = {1'b0, in_den};

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			remx[l] = {in_rem[l], in_num[l][QW-1]};
			ge[l]   = (remx[l] >= dx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// numerator register shifts out dividend bits and shifts in quotient bits
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				out_num[l] <= {in_num[l][QW-2:0], ge[l]};
				out_rem[l] <= ge[l] ? DW'(remx[l] - dx) : remx[l][DW-1:0];
			end
			out_den  <= in_den;
			out_side <= in_side;
		end
	end

endmodule

### rtl/quadratic_root_solver_top.sv
// Top level of the quadratic root solver: front end, square-root and divider chains.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.

// Quadratic root solver. Each input word carries signed coefficients a, b, c
// (tdata, from bit 0: coef_a, coef_b, coef_c, zero padded to whole bytes). Each
// output word carries (from bit 0) status, discriminant, root_minus, root_plus.
// The discriminant b*b-4ac is exact; roots are signed Q.FRAC_BITS, computed as
// trunc((-b*2^F -/+ s)/(2a)) with s = floor(sqrt(delta*2^(2F))). Status: a zero
// (all other fields zero), no real roots (discriminant kept, roots zero), double
// root, two roots. The block has no state between words and accepts one
// word every cycle that the pipe advances. Front-end registers feed a row
// of square-root cells, one root bit per cell, a numerator register, a row of
// divider cells, one quotient bit per cell for both roots at once, and the
// output register. The whole pipe advances whenever the output register is
// empty or being taken, so a full pipe holds while m_axis_tready is low.
module quadratic_root_solver_top #(
	parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// coef_a, coef_b, coef_c from bit 0, zero padded
	input  logic [((3*COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status, discriminant, root_minus, root_plus from bit 0
	output logic [qrs_pkg::OUT_W-1:0]     m_axis_tdata
);
	import qrs_pkg::*;

	localparam int C    = COEF_BITS;
	localparam int F    = FRAC_BITS;
	localparam int DLW  = 2 * C + 2;       // signed discriminant
	localparam int P    = C + F + 1;       // root bits, radicand pairs
	localparam int NBW  = C + F + 1;       // signed -b*2^F
	localparam int QW   = C + F + 2;       // quotient magnitude
	localparam int DENW = C + 1;           // |2a|
	localparam int SSW  = STATUS_BITS + DLW + NBW + 1;   // side data in sqrt row
	localparam int DSW  = STATUS_BITS + DLW + 2;         // side data in divider row

	// advance the whole pipe when the output slot frees up
	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: capture coefficients
	logic                v_s1;
	logic signed [C-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= $signed(s_axis_tdata[C-1:0]);
			b_s1 <= $signed(s_axis_tdata[2*C-1:C]);
			c_s1 <= $signed(s_axis_tdata[3*C-1:2*C]);
		end
	end

	// stage 2: the two products
	logic                  v_s2;
	logic signed [C-1:0]   a_s2, b_s2;
	logic signed [2*C-1:0] bb_s2, ac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
		end
	end

	// stage 3: discriminant, status, radicand and divider operands
	logic signed [DLW-1:0] delta_raw;
	logic signed [DLW-1:0] delta_c;
	status_t               status_c;
	logic signed [NBW-1:0] nb_c;
	logic [C-1:0]          abs_a_c;

	assign delta_raw = DLW'(bb_s2) - $signed({ac_s2, 2'b00});
	assign nb_c      = -($signed({b_s2[C-1], b_s2, {F{1'b0}}}));
	assign abs_a_c   = a_s2[C-1] ? C'(-a_s2) : C'(a_s2);

	always_comb begin
		delta_c  = delta_raw;
		status_c = ST_TWO;
		if (a_s2 == '0) begin
			delta_c  = '0;
			status_c = ST_A_ZERO;
		end else if (delta_raw[DLW-1]) begin
			status_c = ST_NO_REAL;
		end else if (delta_raw == '0) begin
			status_c = ST_DOUBLE;
		end
	end

	logic             sv    [P+1];
	logic [2*P-1:0]   srad  [P+1];
	logic [P-1:0]     sroot [P+1];
	logic [P+2:0]     srem  [P+1];
	logic [SSW-1:0]   sside [P+1];
	logic [DENW-1:0]  den_s3;
	logic [DENW-1:0]  den_q   [P+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv[0] <= 1'b0;
		end else if (adv) begin
			sv[0] <= v_s2;
		end
	end

	// radicand is delta*4^F, one spare zero on top to make whole pairs
	always_ff @(posedge clk) begin
		if (adv) begin
			srad[0]  <= {1'b0, delta_c[2*C:0], {(2*F){1'b0}}};
			sroot[0] <= '0;
			srem[0]  <= '0;
			sside[0] <= {status_c, delta_c, nb_c, a_s2[C-1]};
			den_s3   <= {abs_a_c, 1'b0};
		end
	end

	assign den_q[0] = den_s3;

	// square-root row; divisor rides alongside in plain registers
	for (genvar k = 0; k < P; k++) begin : g_sqrt
		qrs_sqrt_cell #(.P(P), .SW(SSW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (sv[k]),
			.in_rad    (srad[k]),
			.in_root   (sroot[k]),
			.in_rem    (srem[k]),
			.in_side   (sside[k]),
			.out_valid (sv[k+1]),
			.out_rad   (srad[k+1]),
			.out_root  (sroot[k+1]),
			.out_rem   (srem[k+1]),
			.out_side  (sside[k+1])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				den_q[k+1] <= den_q[k];
			end
		end
	end

	// numerator stage: nb -/+ s, split into sign and magnitude
	logic [STATUS_BITS-1:0] st_n;
	logic [DLW-1:0]         dl_n;
	logic signed [NBW-1:0]  nb_n;
	logic                   asg_n;
	logic signed [QW:0]     nm_c, np_c;
	logic signed [QW:0]     s_ext;

	assign {st_n, dl_n, nb_n, asg_n} = sside[P];
	assign s_ext = $signed({2'b00, sroot[P]});
	assign nm_c  = (QW+1)'(nb_n) - s_ext;
	assign np_c  = (QW+1)'(nb_n) + s_ext;

	logic            dv   [QW+1];
	logic [QW-1:0]   dnum [QW+1][2];
	logic [DENW-1:0] drem [QW+1][2];
	logic [DENW-1:0] dden [QW+1];
	logic [DSW-1:0]  dside[QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (adv) begin
			dv[0] <= sv[P];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dnum[0][0] <= nm_c[QW] ? QW'(-nm_c) : QW'(nm_c);
			dnum[0][1] <= np_c[QW] ? QW'(-np_c) : QW'(np_c);
			drem[0][0] <= '0;
			drem[0][1] <= '0;
			dden[0]    <= den_q[P];
			dside[0]   <= {st_n, dl_n, nm_c[QW] ^ asg_n, np_c[QW] ^ asg_n};
		end
	end

	// divider row, both roots in lockstep
	for (genvar k = 0; k < QW; k++) begin : g_div
		qrs_div_cell #(.QW(QW), .DW(DENW), .SW(DSW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (dv[k]),
			.in_num    (dnum[k]),
			.in_rem    (drem[k]),
			.in_den    (dden[k]),
			.in_side   (dside[k]),
			.out_valid (dv[k+1]),
			.out_num   (dnum[k+1]),
			.out_rem   (drem[k+1]),
			.out_den   (dden[k+1]),
			.out_side  (dside[k+1])
		);
	end

	// output stage: apply signs, zero roots unless real, pack the word
	logic [STATUS_BITS-1:0] st_o;
	logic signed [DLW-1:0]  dl_o;
	logic                   negm_o, negp_o;
	logic signed [QW:0]     qm_c, qp_c;
	logic [ROOT_BITS-1:0]   rm_c, rp_c;
	logic                   real_c;

	assign {st_o, dl_o, negm_o, negp_o} = dside[QW];
	assign qm_c   = negm_o ? -$signed({1'b0, dnum[QW][0]}) : $signed({1'b0, dnum[QW][0]});
	assign qp_c   = negp_o ? -$signed({1'b0, dnum[QW][1]}) : $signed({1'b0, dnum[QW][1]});
	assign real_c = (st_o == ST_DOUBLE) || (st_o == ST_TWO);
	assign rm_c   = real_c ? ROOT_BITS'(qm_c) : '0;
	assign rp_c   = real_c ? ROOT_BITS'(qp_c) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= dv[QW];
		end
	end

	// zero-extend the packed fields to the byte-padded word
	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= OUT_W'({rp_c, rm_c, DISC_BITS'(dl_o), st_o});
		end
	end

endmodule

### test/tb_quadratic_root_solver_top.sv
// Testbench for quadratic_root_solver_top: streams coefficient words and checks
// every result word against a built-in predictor of the root arithmetic.
// Depends on qrs_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_quadratic_root_solver_top;
	import qrs_pkg::*;

	localparam int COEF_BITS = COEF_BITS_DEF;
	localparam int FRAC_BITS = FRAC_BITS_DEF;
	localparam int IN_BITS = 3 * COEF_BITS;
	localparam int IN_W = ((3 * COEF_BITS + 7) / 8) * 8;
	localparam int LATENCY = 3 + (COEF_BITS + FRAC_BITS + 1) + 1
		+ (COEF_BITS + FRAC_BITS + 2) + 1;
	localparam int N_RANDOM = 930;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] c;
		logic signed [COEF_BITS-1:0] b;
		logic signed [COEF_BITS-1:0] a;
	} coefs_t;

	typedef struct packed {
		logic signed [ROOT_BITS-1:0] root_plus;
		logic signed [ROOT_BITS-1:0] root_minus;
		logic signed [DISC_BITS-1:0] disc;
		status_t                     status;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	coefs_t coef_queue[$];
	roots_t expected_roots[$];
	int errors = 0;

	quadratic_root_solver_top #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) dut (.*);

	always #5 clk = ~clk;

	// Integer square root of d * 4^FRAC_BITS, rounded down; bit by bit.
	function automatic longint unsigned scaled_isqrt(longint unsigned d);
		logic [127:0] x, r, bitv;
		x = 128'(d) << (2 * FRAC_BITS);
		r = '0;
		bitv = 128'd1 << 126;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(r[63:0]);
	endfunction

	function automatic roots_t solve_roots(coefs_t k);
		roots_t res;
		longint a, b, c, delta, s, nb, den;
		a = k.a;
		b = k.b;
		c = k.c;
		res = '0;
		if (a == 0) begin
			res.status = ST_A_ZERO;
		end else begin
			delta = b * b - 4 * a * c;
			res.disc = delta[DISC_BITS-1:0];
			if (delta < 0) begin
				res.status = ST_NO_REAL;
			end else begin
				s = longint'(scaled_isqrt(delta));
				nb = -(b <<< FRAC_BITS);
				den = 2 * a;
				// SV division of longint truncates toward zero
				res.root_minus = ROOT_BITS'((nb - s) / den);
				res.root_plus = ROOT_BITS'((nb + s) / den);
				res.status = (delta == 0) ? ST_DOUBLE : ST_TWO;
			end
		end
		return res;
	endfunction

	function automatic coefs_t rand_coefs();
		coefs_t k;
		int va, vb, vc;
		k = IN_BITS'({$urandom, $urandom});
		case ($urandom_range(0, 5))
			0: k.a = '0;
			1: begin
				// perfect square: a(x-p)^2 gives a double root
				va = int'($urandom_range(0, 200)) - 100;
				vb = -2 * va * (int'($urandom_range(0, 20)) - 10);
				vc = (va == 0) ? 0 : vb * vb / (4 * va);
				k.a = COEF_BITS'(va);
				k.b = COEF_BITS'(vb);
				k.c = COEF_BITS'(vc);
			end
			2: begin
				va = int'($urandom_range(0, 40)) - 20;
				vb = int'($urandom_range(0, 400)) - 200;
				vc = int'($urandom_range(0, 400)) - 200;
				k.a = COEF_BITS'(va);
				k.b = COEF_BITS'(vb);
				k.c = COEF_BITS'(vc);
			end
			default: ;
		endcase
		return k;
	endfunction

	task automatic queue_coefs(int a, int b, int c);
		coefs_t k;
		k.a = COEF_BITS'(a);
		k.b = COEF_BITS'(b);
		k.c = COEF_BITS'(c);
		coef_queue.push_back(k);
	endtask

	initial begin
		int lo, hi;
		lo = -(1 << (COEF_BITS - 1));
		hi = (1 << (COEF_BITS - 1)) - 1;
		// a zero, no real roots, double root, two roots
		queue_coefs(0, 5, 7);
		queue_coefs(0, lo, hi);
		queue_coefs(1, 0, 1);
		queue_coefs(1, -2, 1);
		queue_coefs(-3, 12, -12);
		queue_coefs(1, -3, 2);
		queue_coefs(-1, 0, 4);
		queue_coefs(2, 1, -3);
		// extremes of every field
		queue_coefs(lo, lo, lo);
		queue_coefs(lo, lo, hi);
		queue_coefs(hi, hi, hi);
		queue_coefs(hi, lo, lo);
		queue_coefs(lo, hi, hi);
		queue_coefs(1, lo, hi);
		queue_coefs(1, hi, lo);
		queue_coefs(-1, lo, 0);
		queue_coefs(hi, 0, lo);
		queue_coefs(lo, 0, lo);
		queue_coefs(-1, -1, -1);
		queue_coefs(1, 1, 0);
		for (int i = 0; i < N_RANDOM; i++) coef_queue.push_back(rand_coefs());
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (coef_queue.size() == 0 && !s_axis_tvalid);
		wait (expected_roots.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Run limit: items plus worst-case stalls, many times over.
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	// Driver: bursts of words with random gaps; hold a word until it is taken.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the current word
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (coef_queue.size() > 0) begin
				s_axis_tdata <= IN_W'(coef_queue.pop_front());
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: alternating phases of steady and random ready.
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= (stall_phase + 1) % 300;
		if (stall_phase < 100) m_axis_tready <= 1'b1;
		else if (stall_phase < 200) m_axis_tready <= ($urandom_range(0, 3) != 0);
		else m_axis_tready <= ($urandom_range(0, 1) != 0);
	end

	// Monitor: predict on each accepted input word, check each accepted output word.
	always @(posedge clk) begin
		roots_t got, want;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_roots.push_back(solve_roots(coefs_t'(s_axis_tdata[3*COEF_BITS-1:0])));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = roots_t'(m_axis_tdata[OUT_BITS-1:0]);
			if (expected_roots.size() == 0) begin
				$error("result word with no expectation: %h", got);
				errors++;
			end else begin
				want = expected_roots.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					errors++;
				end
				if (got.disc !== want.disc) begin
					$error("discriminant: expected %0d, actual %0d", want.disc, got.disc);
					errors++;
				end
				if (got.root_minus !== want.root_minus) begin
					$error("root_minus: expected %0d, actual %0d",
						want.root_minus, got.root_minus);
					errors++;
				end
				if (got.root_plus !== want.root_plus) begin
					$error("root_plus: expected %0d, actual %0d",
						want.root_plus, got.root_plus);
					errors++;
				end
			end
		end
	end

endmodule
